FILE: sv/rdi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rdi_pkg;

  localparam int MIN_DISTANCE = 66;

  typedef enum logic [2:0] {
    REG_CENTER_X     = 3'd0,
    REG_CENTER_Y     = 3'd1,
    REG_CENTER_Z     = 3'd2,
    REG_NORMAL_X     = 3'd3,
    REG_NORMAL_Y     = 3'd4,
    REG_NORMAL_Z     = 3'd5,
    REG_OUTER_RADIUS = 3'd6,
    REG_INNER_RADIUS = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [31:0] center_x;
    logic [31:0] center_y;
    logic [31:0] center_z;
    logic [17:0] normal_x;
    logic [17:0] normal_y;
    logic [17:0] normal_z;
    logic [30:0] outer_radius;
    logic [30:0] inner_radius;
  } cfg_t;

  typedef struct packed {
    logic [2:0][32:0] rel;
    logic [2:0][17:0] dir;
    logic [30:0]      maxd;
  } pass_t;

  typedef struct packed {
    logic [52:0] an;
    logic [37:0] ad;
    logic        neg;
    logic        drop;
    pass_t       pass;
  } ray_job_t;

  typedef struct packed {
    logic        ok;
    logic [30:0] tval;
    pass_t       pass;
  } div_res_t;

endpackage
`default_nettype wire

FILE: sv/rdi_front.sv
`timescale 1ns / 1ps
`default_nettype none
module rdi_front (
  input  logic               clk,
  input  logic               rst_n,
  input  rdi_pkg::cfg_t      cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_origin_x,
  input  logic signed [31:0] in_origin_y,
  input  logic signed [31:0] in_origin_z,
  input  logic signed [17:0] in_dir_x,
  input  logic signed [17:0] in_dir_y,
  input  logic signed [17:0] in_dir_z,
  input  logic        [30:0] in_max_distance,
  input  logic               q_full,
  output logic               job_valid,
  output rdi_pkg::ray_job_t  job
);
  import rdi_pkg::*;

  logic              adv;
  logic              v1_r, v2_r, v3_r;
  logic [31:0]       org [3];
  logic [31:0]       ctr [3];
  logic [17:0]       nrm [3];
  logic [17:0]       dir_in [3];
  logic [32:0]       rel1_r [3];
  logic [17:0]       dir1_r [3];
  logic [30:0]       maxd1_r;
  logic signed [50:0] np2_r [3];
  logic signed [35:0] dp2_r [3];
  logic [32:0]       rel2_r [3];
  logic [17:0]       dir2_r [3];
  logic [30:0]       maxd2_r;
  logic [52:0]       snum;
  logic [37:0]       den;
  ray_job_t          job_nxt;
  ray_job_t          job_r;

  assign adv      = !v3_r || !q_full;
  assign in_ready = adv;

  assign org[0] = in_origin_x;
  assign org[1] = in_origin_y;
  assign org[2] = in_origin_z;
  assign dir_in[0] = in_dir_x;
  assign dir_in[1] = in_dir_y;
  assign dir_in[2] = in_dir_z;
  assign ctr[0] = cfg.center_x;
  assign ctr[1] = cfg.center_y;
  assign ctr[2] = cfg.center_z;
  assign nrm[0] = cfg.normal_x;
  assign nrm[1] = cfg.normal_y;
  assign nrm[2] = cfg.normal_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        rel1_r[i] <= {org[i][31], org[i]} - {ctr[i][31], ctr[i]};
        dir1_r[i] <= dir_in[i];
        np2_r[i]  <= $signed(rel1_r[i]) * $signed(nrm[i]);
        dp2_r[i]  <= $signed(dir1_r[i]) * $signed(nrm[i]);
        rel2_r[i] <= rel1_r[i];
        dir2_r[i] <= dir1_r[i];
      end
      maxd1_r <= in_max_distance;
      maxd2_r <= maxd1_r;
      job_r   <= job_nxt;
    end
  end

  // The sum of rel * n is the negated numerator.
  always_comb begin
    snum = {{2{np2_r[0][50]}}, np2_r[0]} + {{2{np2_r[1][50]}}, np2_r[1]}
         + {{2{np2_r[2][50]}}, np2_r[2]};
    den  = {{2{dp2_r[0][35]}}, dp2_r[0]} + {{2{dp2_r[1][35]}}, dp2_r[1]}
         + {{2{dp2_r[2][35]}}, dp2_r[2]};
    job_nxt.an   = snum[52] ? (53'd0 - snum) : snum;
    job_nxt.ad   = den[37] ? (38'd0 - den) : den;
    job_nxt.neg  = (!snum[52] && (snum != 53'd0)) != den[37];
    job_nxt.drop = (den == 38'd0);
    for (int i = 0; i < 3; i++) begin
      job_nxt.pass.rel[i] = rel2_r[i];
      job_nxt.pass.dir[i] = dir2_r[i];
    end
    job_nxt.pass.maxd = maxd2_r;
  end

  assign job_valid = v3_r;
  assign job       = job_r;

endmodule
`default_nettype wire

FILE: sv/rdi_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module rdi_queue #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  rdi_pkg::ray_job_t push_data,
  output logic              full,
  input  logic              pop,
  output logic              out_valid,
  output rdi_pkg::ray_job_t out_data
);
  import rdi_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  ray_job_t        mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   count_r;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop) rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (push && !pop) count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  assign full      = (count_r == CW'(DEPTH));
  assign out_valid = (count_r != '0);
  assign out_data  = mem_r[rd_ptr_r];

endmodule
`default_nettype wire

FILE: sv/rdi_divide.sv
`timescale 1ns / 1ps
`default_nettype none
module rdi_divide (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  rdi_pkg::ray_job_t job,
  output logic              out_valid,
  output rdi_pkg::div_res_t res
);
  import rdi_pkg::*;

  localparam int QB = 31;

  logic          v_r    [QB+1];
  logic          ok_r   [QB+1];
  logic          neg_r  [QB+1];
  logic [37:0]   rem_r  [QB+1];
  logic [37:0]   ad_r   [QB+1];
  logic [14:0]   anlo_r [QB+1];
  logic [QB-1:0] q_r    [QB+1];
  pass_t         pass_r [QB+1];
  logic          ovf;

  // The quotient must stay below 2^31, that is an < ad * 2^15.
  assign ovf = job.an >= {job.ad, 15'd0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ok_r[0]   <= !job.drop && !ovf;
      neg_r[0]  <= job.neg;
      rem_r[0]  <= job.an[52:15];
      ad_r[0]   <= job.ad;
      anlo_r[0] <= job.an[14:0];
      q_r[0]    <= '0;
      pass_r[0] <= job.pass;
    end
  end

  for (genvar s = 1; s <= QB; s++) begin : g_stage
    localparam int IDX = QB - s;
    logic        inbit;
    logic [39:0] diff;

    if (IDX >= 16) begin : g_hi
      assign inbit = anlo_r[s-1][IDX-16];
    end else begin : g_lo
      assign inbit = 1'b0;
    end

    assign diff = {1'b0, rem_r[s-1], inbit} - {2'b00, ad_r[s-1]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en) begin
        v_r[s] <= v_r[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ok_r[s]   <= ok_r[s-1];
        neg_r[s]  <= neg_r[s-1];
        ad_r[s]   <= ad_r[s-1];
        anlo_r[s] <= anlo_r[s-1];
        pass_r[s] <= pass_r[s-1];
        if (!diff[39]) begin
          rem_r[s]    <= diff[37:0];
          q_r[s]      <= q_r[s-1] | (QB'(1) << IDX);
        end else begin
          rem_r[s]    <= {rem_r[s-1][36:0], inbit};
          q_r[s]      <= q_r[s-1];
        end
      end
    end
  end

  assign out_valid = v_r[QB];
  assign res.ok    = ok_r[QB] && !(neg_r[QB] && (q_r[QB] != '0));
  assign res.tval  = q_r[QB];
  assign res.pass  = pass_r[QB];

endmodule
`default_nettype wire

FILE: sv/rdi_radius.sv
`timescale 1ns / 1ps
`default_nettype none
module rdi_radius (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  rdi_pkg::cfg_t    cfg,
  input  logic             in_valid,
  input  rdi_pkg::div_res_t res,
  output logic             out_valid,
  output logic             out_hit,
  output logic [30:0]      out_hit_distance
);
  import rdi_pkg::*;

  logic               v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic               ok1_r, ok2_r, ok3_r, ok4_r, ok5_r;
  logic [30:0]        dist1_r, dist2_r, dist3_r, dist4_r, dist5_r;
  logic [30:0]        maxd1_r, maxd2_r, maxd3_r, maxd4_r, maxd5_r;
  logic signed [49:0] p1_r [3];
  logic [32:0]        rel1_r [3];
  logic [49:0]        ae2_r [3];
  logic [50:0]        e2 [3];
  logic [49:0]        hh3_r [3];
  logic [49:0]        hl3_r [3];
  logic [49:0]        ll3_r [3];
  logic [61:0]        o2_3_r, i2_3_r, o2_4_r, i2_4_r, o2_5_r, i2_5_r;
  logic [99:0]        sq4_r [3];
  logic [101:0]       r2_5_r;
  logic               rad_ok;
  logic               hit_r;
  logic [30:0]        hit_distance_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e2[i] = {{2{rel1_r[i][32]}}, rel1_r[i], 16'd0} + {p1_r[i][49], p1_r[i]};
    end
  end

  assign rad_ok = (r2_5_r <= {8'd0, o2_5_r, 32'd0}) && (r2_5_r >= {8'd0, i2_5_r, 32'd0});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ok1_r   <= res.ok && (res.tval >= 31'(MIN_DISTANCE)) && (res.tval <= res.pass.maxd);
      dist1_r <= res.tval;
      maxd1_r <= res.pass.maxd;
      for (int i = 0; i < 3; i++) begin
        p1_r[i]   <= $signed(res.pass.dir[i]) * $signed({1'b0, res.tval});
        rel1_r[i] <= res.pass.rel[i];
        ae2_r[i]  <= e2[i][50] ? 50'(51'd0 - e2[i]) : e2[i][49:0];
        hh3_r[i]  <= ae2_r[i][49:25] * ae2_r[i][49:25];
        hl3_r[i]  <= ae2_r[i][49:25] * ae2_r[i][24:0];
        ll3_r[i]  <= ae2_r[i][24:0] * ae2_r[i][24:0];
        sq4_r[i]  <= {hh3_r[i], 50'd0} + {24'd0, hl3_r[i], 26'd0} + {50'd0, ll3_r[i]};
      end
      ok2_r   <= ok1_r;
      dist2_r <= dist1_r;
      maxd2_r <= maxd1_r;
      ok3_r   <= ok2_r;
      dist3_r <= dist2_r;
      maxd3_r <= maxd2_r;
      o2_3_r  <= cfg.outer_radius * cfg.outer_radius;
      i2_3_r  <= cfg.inner_radius * cfg.inner_radius;
      ok4_r   <= ok3_r;
      dist4_r <= dist3_r;
      maxd4_r <= maxd3_r;
      o2_4_r  <= o2_3_r;
      i2_4_r  <= i2_3_r;
      ok5_r   <= ok4_r;
      dist5_r <= dist4_r;
      maxd5_r <= maxd4_r;
      o2_5_r  <= o2_4_r;
      i2_5_r  <= i2_4_r;
      r2_5_r  <= {2'd0, sq4_r[0]} + {2'd0, sq4_r[1]} + {2'd0, sq4_r[2]};
      hit_r          <= ok5_r && rad_ok;
      hit_distance_r <= (ok5_r && rad_ok) ? dist5_r : maxd5_r;
    end
  end

  assign out_valid        = v6_r;
  assign out_hit          = hit_r;
  assign out_hit_distance = hit_distance_r;

endmodule
`default_nettype wire

FILE: sv/ray_disc_intersect_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Tests one ray per beat against a configured annulus and returns hit and the new nearest
// distance, one ray per clock sustained while out_ready is held high. A ray passes through
// the front stages that form the plane dot products, the job queue, the pipelined restoring
// divider (an input register, then one quotient bit per stage) and the radius check. The
// queue of QDEPTH entries (at least two) lets the front keep accepting rays while the result
// side is stalled, until the queue fills.
module ray_disc_intersect_unit #(
  parameter int QDEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic        [2:0]  cfg_index,
  input  logic        [31:0] cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_origin_x,
  input  logic signed [31:0] in_origin_y,
  input  logic signed [31:0] in_origin_z,
  input  logic signed [17:0] in_dir_x,
  input  logic signed [17:0] in_dir_y,
  input  logic signed [17:0] in_dir_z,
  input  logic        [30:0] in_max_distance,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_hit,
  output logic        [30:0] out_hit_distance
);
  import rdi_pkg::*;

  cfg_t     cfg_r;
  logic     f_valid;
  ray_job_t f_job;
  logic     q_full;
  logic     q_valid;
  ray_job_t q_job;
  logic     q_push;
  logic     q_pop;
  logic     b_en;
  logic     d_valid;
  div_res_t d_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.center_x     <= '0;
      cfg_r.center_y     <= '0;
      cfg_r.center_z     <= '0;
      cfg_r.normal_x     <= '0;
      cfg_r.normal_y     <= '0;
      cfg_r.normal_z     <= 18'd65536;
      cfg_r.outer_radius <= 31'd65536;
      cfg_r.inner_radius <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CENTER_X:     cfg_r.center_x     <= cfg_wdata;
        REG_CENTER_Y:     cfg_r.center_y     <= cfg_wdata;
        REG_CENTER_Z:     cfg_r.center_z     <= cfg_wdata;
        REG_NORMAL_X:     cfg_r.normal_x     <= cfg_wdata[17:0];
        REG_NORMAL_Y:     cfg_r.normal_y     <= cfg_wdata[17:0];
        REG_NORMAL_Z:     cfg_r.normal_z     <= cfg_wdata[17:0];
        REG_OUTER_RADIUS: cfg_r.outer_radius <= cfg_wdata[30:0];
        REG_INNER_RADIUS: cfg_r.inner_radius <= cfg_wdata[30:0];
        default: ;
      endcase
    end
  end

  rdi_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_origin_x     (in_origin_x),
    .in_origin_y     (in_origin_y),
    .in_origin_z     (in_origin_z),
    .in_dir_x        (in_dir_x),
    .in_dir_y        (in_dir_y),
    .in_dir_z        (in_dir_z),
    .in_max_distance (in_max_distance),
    .q_full          (q_full),
    .job_valid       (f_valid),
    .job             (f_job)
  );

  assign q_push = f_valid && !q_full;
  assign b_en   = !out_valid || out_ready;
  assign q_pop  = q_valid && b_en;

  rdi_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (f_job),
    .full      (q_full),
    .pop       (q_pop),
    .out_valid (q_valid),
    .out_data  (q_job)
  );

  rdi_divide u_divide (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (b_en),
    .in_valid  (q_valid),
    .job       (q_job),
    .out_valid (d_valid),
    .res       (d_res)
  );

  rdi_radius u_radius (
    .clk              (clk),
    .rst_n            (rst_n),
    .en               (b_en),
    .cfg              (cfg_r),
    .in_valid         (d_valid),
    .res              (d_res),
    .out_valid        (out_valid),
    .out_hit          (out_hit),
    .out_hit_distance (out_hit_distance)
  );

`ifndef SYNTHESIS
  ap_hit_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> out_hit_distance >= 31'(MIN_DISTANCE))
    else $error("hit reported below the minimum distance");

  ap_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> q_full)
    else $error("input stalled while the job queue had room");
`endif

endmodule
`default_nettype wire
